// ===== rtl/pbr_pkg.sv =====
`default_nettype none

package pbr_pkg;

    localparam int MAX_DEGREE = 6;
    localparam int MAX_ITER   = 48;
    localparam int TOL_LSB    = 7;

    localparam int X_W        = 32;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 64;
    localparam int COEF_W     = 16;
    localparam int DEGREE_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int ITER_W     = 6;
    localparam int NUM_COEF   = MAX_DEGREE + 1;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    localparam int ITER_CNT_W = $clog2(MAX_ITER + 1);

    localparam int IN_TDATA_W  = 2 * X_W;
    localparam int OUT_TDATA_W = X_W + STATUS_W + ITER_W;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = COEF_W;

    localparam logic [CFG_INDEX_W-1:0] REG_DEGREE    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_BASE = 4'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_SAME_SIGN = 2'd1,
        ST_LIMIT     = 2'd2
    } status_t;

    // Which point the polynomial is evaluated at.
    typedef enum logic [1:0] {
        PT_A,
        PT_B,
        PT_C
    } pt_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t coef_arr_t [NUM_COEF];

    typedef struct packed {
        logic                  load_ab;
        logic                  eval_init;
        logic                  step_mag;
        logic                  step_mul;
        logic                  step_sat;
        logic                  step_add;
        logic                  store_fa;
        logic                  mid;
        logic                  bisect;
        pt_t                   x_sel;
        logic [COEF_IDX_W-1:0] coef_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic same_sign;
        logic in_tol;
        logic iter_max;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pbr_datapath.sv =====
`default_nettype none

module pbr_datapath (
    input  wire logic                                aclk,
    input  wire pbr_pkg::dp_cmd_t                    cmd,
    input  wire logic signed [pbr_pkg::X_W-1:0]      lower_bound,
    input  wire logic signed [pbr_pkg::X_W-1:0]      upper_bound,
    input  wire pbr_pkg::coef_arr_t                  coef,
    output pbr_pkg::dp_stat_t                        stat,
    output logic signed [pbr_pkg::X_W-1:0]           mid_point,
    output logic [pbr_pkg::ITER_CNT_W-1:0]           iter_count
);

    localparam int XW = pbr_pkg::X_W;
    localparam int AW = pbr_pkg::ACC_W;
    localparam int FW = pbr_pkg::FRAC_W;
    localparam int CW = pbr_pkg::COEF_W;

    localparam logic [AW-1:0] LIM_NEG = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0] LIM_POS = {1'b0, {(AW-1){1'b1}}};

    logic signed [XW-1:0] a_reg, b_reg, c_reg;
    logic signed [AW-1:0] fa_reg, acc_reg;
    logic [XW-1:0]        mx_reg;
    logic                 xneg_reg;
    logic [AW-1:0]        ma_reg;
    logic                 neg_reg;
    logic [AW-1:0]        p_reg, q_reg, val_reg;
    logic [pbr_pkg::ITER_CNT_W-1:0] iter_reg;

    logic signed [XW-1:0] x_sel_val;
    logic [XW-1:0]        x_mag;
    logic signed [CW-1:0] coef_sel;
    logic [AW-1:0]        acc_mag;
    logic [AW-1:0]        p_prod, q_prod;
    logic [AW-1:0]        lim;
    logic [AW:0]          sum_mag;
    logic [AW-1:0]        val_next;
    logic signed [AW+1:0] coef_wide, sum_acc;
    logic signed [AW-1:0] acc_next;
    logic signed [XW:0]   ab_sum;
    logic                 acc_pos, acc_neg, fa_pos, fa_neg;

    always_comb begin
        unique case (cmd.x_sel)
            pbr_pkg::PT_A: x_sel_val = a_reg;
            pbr_pkg::PT_B: x_sel_val = b_reg;
            default:       x_sel_val = c_reg;
        endcase
    end

    assign x_mag    = x_sel_val[XW-1] ? (~x_sel_val + XW'(1)) : x_sel_val;
    assign coef_sel = coef[cmd.coef_idx];
    assign acc_mag  = acc_reg[AW-1] ? (~acc_reg + AW'(1)) : acc_reg;

    assign p_prod = ma_reg[XW-1:0] * mx_reg;
    assign q_prod = ma_reg[AW-1:XW] * mx_reg;

    // Magnitude of (acc * x) >> 16, clipped to the limit of the result's sign.
    assign lim     = neg_reg ? LIM_NEG : LIM_POS;
    assign sum_mag = {1'b0, q_reg[AW-FW-1:0], {FW{1'b0}}}
                   + {{(FW+1){1'b0}}, p_reg[AW-1:FW]};
    assign val_next = ((q_reg > (lim >> FW)) || (sum_mag > {1'b0, lim})) ? lim
                    : sum_mag[AW-1:0];

    // Exact sum of the signed product and the scaled coefficient, then clamp.
    assign coef_wide = {{(AW+2-CW-FW){coef_sel[CW-1]}}, coef_sel, {FW{1'b0}}};
    assign sum_acc   = neg_reg ? (coef_wide - $signed({2'b00, val_reg}))
                               : (coef_wide + $signed({2'b00, val_reg}));

    always_comb begin
        if (sum_acc[AW+1:AW-1] == 3'b000 || sum_acc[AW+1:AW-1] == 3'b111) begin
            acc_next = sum_acc[AW-1:0];
        end else if (sum_acc[AW+1]) begin
            acc_next = LIM_NEG;
        end else begin
            acc_next = LIM_POS;
        end
    end

    assign ab_sum = {a_reg[XW-1], a_reg} + {b_reg[XW-1], b_reg};

    assign acc_pos = !acc_reg[AW-1] && (acc_reg != '0);
    assign acc_neg = acc_reg[AW-1];
    assign fa_pos  = !fa_reg[AW-1] && (fa_reg != '0);
    assign fa_neg  = fa_reg[AW-1];

    always_comb begin
        stat.same_sign = (fa_pos && acc_pos) || (fa_neg && acc_neg);
        stat.in_tol    = (acc_reg > -AW'(pbr_pkg::TOL_LSB))
                      && (acc_reg < AW'(pbr_pkg::TOL_LSB));
        stat.iter_max  = (iter_reg == pbr_pkg::ITER_CNT_W'(pbr_pkg::MAX_ITER));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_ab) begin
            a_reg    <= lower_bound;
            b_reg    <= upper_bound;
            iter_reg <= '0;
        end
        if (cmd.eval_init) begin
            acc_reg  <= {{(AW-CW-FW){coef_sel[CW-1]}}, coef_sel, {FW{1'b0}}};
            mx_reg   <= x_mag;
            xneg_reg <= x_sel_val[XW-1];
        end
        if (cmd.step_mag) begin
            ma_reg  <= acc_mag;
            neg_reg <= acc_reg[AW-1] ^ xneg_reg;
        end
        if (cmd.step_mul) begin
            p_reg <= p_prod;
            q_reg <= q_prod;
        end
        if (cmd.step_sat) begin
            val_reg <= val_next;
        end
        if (cmd.step_add) begin
            acc_reg <= acc_next;
        end
        if (cmd.store_fa) begin
            fa_reg <= acc_reg;
        end
        if (cmd.mid) begin
            c_reg <= ab_sum[XW:1];
        end
        if (cmd.bisect) begin
            // Keep the lower half only on a strict sign change between a and c.
            if ((fa_pos && acc_neg) || (fa_neg && acc_pos)) begin
                b_reg <= c_reg;
            end else begin
                a_reg  <= c_reg;
                fa_reg <= acc_reg;
            end
            iter_reg <= iter_reg + pbr_pkg::ITER_CNT_W'(1);
        end
    end

    assign mid_point  = c_reg;
    assign iter_count = iter_reg;

endmodule

`default_nettype wire

// ===== rtl/pbr_ctrl.sv =====
`default_nettype none

module pbr_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [pbr_pkg::COEF_IDX_W-1:0]     degree_eff,
    input  wire logic                               out_free,
    input  wire pbr_pkg::dp_stat_t                  stat,
    output pbr_pkg::dp_cmd_t                        cmd,
    output logic                                    push,
    output pbr_pkg::status_t                        push_code
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_MAG,
        S_MUL,
        S_SAT,
        S_ADD,
        S_EVDONE,
        S_MID,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    pbr_pkg::pt_t                    pt_reg;
    logic [pbr_pkg::COEF_IDX_W-1:0]  step_reg;
    pbr_pkg::status_t                code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pt_reg    <= pbr_pkg::PT_A;
            step_reg  <= '0;
            code_reg  <= pbr_pkg::ST_FOUND;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        pt_reg    <= pbr_pkg::PT_A;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT: begin
                    step_reg  <= degree_eff;
                    state_reg <= (degree_eff == '0) ? S_EVDONE : S_MAG;
                end
                S_MAG: state_reg <= S_MUL;
                S_MUL: state_reg <= S_SAT;
                S_SAT: state_reg <= S_ADD;
                S_ADD: begin
                    step_reg  <= step_reg - pbr_pkg::COEF_IDX_W'(1);
                    state_reg <= (step_reg == pbr_pkg::COEF_IDX_W'(1)) ? S_EVDONE : S_MAG;
                end
                S_EVDONE: begin
                    unique case (pt_reg)
                        pbr_pkg::PT_A: begin
                            pt_reg    <= pbr_pkg::PT_B;
                            state_reg <= S_INIT;
                        end
                        pbr_pkg::PT_B: begin
                            if (stat.same_sign) begin
                                code_reg  <= pbr_pkg::ST_SAME_SIGN;
                                state_reg <= S_FINISH;
                            end else begin
                                state_reg <= S_MID;
                            end
                        end
                        default: begin
                            priority if (stat.in_tol) begin
                                code_reg  <= pbr_pkg::ST_FOUND;
                                state_reg <= S_FINISH;
                            end else if (stat.iter_max) begin
                                code_reg  <= pbr_pkg::ST_LIMIT;
                                state_reg <= S_FINISH;
                            end else begin
                                state_reg <= S_MID;
                            end
                        end
                    endcase
                end
                S_MID: begin
                    pt_reg    <= pbr_pkg::PT_C;
                    state_reg <= S_INIT;
                end
                S_FINISH: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.x_sel     = pt_reg;
        cmd.coef_idx  = degree_eff;
        cmd.load_ab   = (state_reg == S_IDLE) && in_valid;
        cmd.eval_init = (state_reg == S_INIT);
        cmd.step_mag  = (state_reg == S_MAG);
        cmd.step_mul  = (state_reg == S_MUL);
        cmd.step_sat  = (state_reg == S_SAT);
        cmd.step_add  = (state_reg == S_ADD);
        if (state_reg == S_ADD) begin
            cmd.coef_idx = step_reg - pbr_pkg::COEF_IDX_W'(1);
        end
        cmd.store_fa  = (state_reg == S_EVDONE) && (pt_reg == pbr_pkg::PT_A);
        // Moving to the next midpoint from a checked c means one more halving.
        cmd.bisect    = (state_reg == S_EVDONE) && (pt_reg == pbr_pkg::PT_C)
                     && !stat.in_tol && !stat.iter_max;
        cmd.mid       = (state_reg == S_MID);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign push      = (state_reg == S_FINISH) && out_free;
    assign push_code = code_reg;

endmodule

`default_nettype wire

// ===== rtl/polynomial_bisection_root_core.sv =====
// Bisection root finder for an integer-coefficient polynomial of degree up to six over a
// signed Q16.16 interval. Each beat on the input carries the interval ends; each produces
// exactly one result beat with the final midpoint (zero on a same-sign interval), a status
// code and the halving count. The polynomial is evaluated by Horner's rule with a saturating
// 64-bit accumulator; each Horner step runs through magnitude, a pair of 32x32 multiplies,
// clip and add. A same-sign interval finishes after the two end-point evaluations. The next
// item is taken as soon as the result is moved to the output register, even while that
// result waits. Configuration writes are accepted on every cycle and must only be issued
// while idle.
`default_nettype none

module polynomial_bisection_root_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input beat: lower_bound [31:0], upper_bound [63:32].
    input  wire logic [pbr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Result beat: root [31:0], status [33:32], iterations [39:34].
    output logic [pbr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pbr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pbr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int XW = pbr_pkg::X_W;

    logic [pbr_pkg::DEGREE_W-1:0]    degree_reg;
    pbr_pkg::coef_arr_t              coef_reg;
    logic [pbr_pkg::COEF_IDX_W-1:0]  degree_eff;

    logic                            m_valid_reg;
    logic [XW-1:0]                   root_reg;
    pbr_pkg::status_t                status_reg;
    logic [pbr_pkg::ITER_W-1:0]      iter_out_reg;

    pbr_pkg::dp_cmd_t                cmd;
    pbr_pkg::dp_stat_t               stat;
    logic                            out_free;
    logic                            push;
    pbr_pkg::status_t                push_code;
    logic signed [XW-1:0]            mid_point;
    logic [pbr_pkg::ITER_CNT_W-1:0]  iter_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= '0;
            for (int i = 0; i < pbr_pkg::NUM_COEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == pbr_pkg::REG_DEGREE) begin
                degree_reg <= cfg_data[pbr_pkg::DEGREE_W-1:0];
            end
            for (int i = 0; i < pbr_pkg::NUM_COEF; i++) begin
                if (cfg_index == pbr_pkg::REG_COEF_BASE + pbr_pkg::CFG_INDEX_W'(i)) begin
                    coef_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign degree_eff = (degree_reg > pbr_pkg::DEGREE_W'(pbr_pkg::MAX_DEGREE))
                      ? pbr_pkg::COEF_IDX_W'(pbr_pkg::MAX_DEGREE)
                      : pbr_pkg::COEF_IDX_W'(degree_reg);

    assign out_free = !m_valid_reg || m_axis_tready;

    pbr_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .degree_eff (degree_eff),
        .out_free   (out_free),
        .stat       (stat),
        .cmd        (cmd),
        .push       (push),
        .push_code  (push_code)
    );

    pbr_datapath u_datapath (
        .aclk        (aclk),
        .cmd         (cmd),
        .lower_bound (s_axis_tdata[XW-1:0]),
        .upper_bound (s_axis_tdata[2*XW-1:XW]),
        .coef        (coef_reg),
        .stat        (stat),
        .mid_point   (mid_point),
        .iter_count  (iter_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            root_reg     <= (push_code == pbr_pkg::ST_SAME_SIGN) ? '0 : mid_point;
            status_reg   <= push_code;
            iter_out_reg <= pbr_pkg::ITER_W'(iter_count);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {iter_out_reg, status_reg, root_reg};

endmodule

`default_nettype wire

// ===== rtl/pbr_checker.sv =====
`default_nettype none

module pbr_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic [pbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready
);

    logic [1:0] st;
    logic [5:0] iters;

    assign st    = m_axis_tdata[33:32];
    assign iters = m_axis_tdata[39:34];

    // No result beat may be offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_same_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st == pbr_pkg::ST_SAME_SIGN |-> m_axis_tdata[31:0] == '0
                                                        && iters == '0)
        else $error("same-sign result carries a root or a count");

    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st == pbr_pkg::ST_LIMIT |-> iters == 6'(pbr_pkg::MAX_ITER))
        else $error("limit status without the full halving count");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (st == pbr_pkg::ST_FOUND || st == pbr_pkg::ST_SAME_SIGN
                           || st == pbr_pkg::ST_LIMIT))
        else $error("undefined status code on a result beat");

endmodule

bind polynomial_bisection_root_core pbr_checker u_pbr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 1400;
    localparam int LONG_HOLD    = 5000;
    localparam int CONFIGS_PER_PHASE = 6;
    localparam int ITEMS_PER_CONFIG  = 39;

    localparam logic [pbr_pkg::CFG_INDEX_W-1:0] REG_UNUSED_BASE =
        pbr_pkg::CFG_INDEX_W'(pbr_pkg::REG_COEF_BASE + pbr_pkg::NUM_COEF);

    localparam logic signed [pbr_pkg::X_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [pbr_pkg::X_W-1:0] X_MIN = 32'sh8000_0000;
    localparam logic signed [pbr_pkg::X_W-1:0] X_MAX = 32'sh7fff_ffff;

    // Root in the low bits, then status, then the halving count.
    typedef struct packed {
        logic [pbr_pkg::ITER_W-1:0] iterations;
        pbr_pkg::status_t           status;
        logic [pbr_pkg::X_W-1:0]    root;
    } root_result_t;

    class root_scoreboard;
        logic [pbr_pkg::DEGREE_W-1:0] degree;
        pbr_pkg::coef_t               coef [pbr_pkg::NUM_COEF];
        root_result_t                 expected_q [$];
        int                           errors;

        function new();
            degree = '0;
            foreach (coef[i]) coef[i] = '0;
            errors = 0;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 40) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endtask

        function void write_reg(logic [pbr_pkg::CFG_INDEX_W-1:0] idx,
                                logic [pbr_pkg::CFG_DATA_W-1:0] val);
            if (idx == pbr_pkg::REG_DEGREE) begin
                degree = val[pbr_pkg::DEGREE_W-1:0];
            end else if (idx >= pbr_pkg::REG_COEF_BASE
                         && idx < pbr_pkg::REG_COEF_BASE + pbr_pkg::NUM_COEF) begin
                coef[pbr_pkg::COEF_IDX_W'(idx - pbr_pkg::REG_COEF_BASE)] = val;
            end
        endfunction

        function logic signed [pbr_pkg::ACC_W-1:0] coef_term(pbr_pkg::coef_t c);
            return {{(pbr_pkg::ACC_W-pbr_pkg::COEF_W-pbr_pkg::FRAC_W){c[pbr_pkg::COEF_W-1]}},
                    c, {pbr_pkg::FRAC_W{1'b0}}};
        endfunction

        function logic signed [pbr_pkg::ACC_W-1:0] sat_sum(
                logic signed [pbr_pkg::ACC_W-1:0] x, y);
            logic [pbr_pkg::ACC_W:0] s;
            s = {x[pbr_pkg::ACC_W-1], x} + {y[pbr_pkg::ACC_W-1], y};
            if (s[pbr_pkg::ACC_W] != s[pbr_pkg::ACC_W-1]) begin
                return s[pbr_pkg::ACC_W] ? {1'b1, {(pbr_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(pbr_pkg::ACC_W-1){1'b1}}};
            end
            return s[pbr_pkg::ACC_W-1:0];
        endfunction

        // Q16.16 product on magnitudes, truncated, clipped, then signed.
        function logic signed [pbr_pkg::ACC_W-1:0] scaled_product(
                logic signed [pbr_pkg::ACC_W-1:0] acc, x);
            logic                         neg;
            logic [2*pbr_pkg::ACC_W-1:0]  ma, mx, p;
            logic [pbr_pkg::ACC_W-1:0]    lim, v;
            neg = acc[pbr_pkg::ACC_W-1] ^ x[pbr_pkg::ACC_W-1];
            ma = '0;
            mx = '0;
            ma[pbr_pkg::ACC_W-1:0] = acc[pbr_pkg::ACC_W-1] ? (~acc + 1'b1) : acc;
            mx[pbr_pkg::ACC_W-1:0] = x[pbr_pkg::ACC_W-1] ? (~x + 1'b1) : x;
            p = (ma * mx) >> pbr_pkg::FRAC_W;
            lim = neg ? {1'b1, {(pbr_pkg::ACC_W-1){1'b0}}} : {1'b0, {(pbr_pkg::ACC_W-1){1'b1}}};
            v = (p > {{pbr_pkg::ACC_W{1'b0}}, lim}) ? lim : p[pbr_pkg::ACC_W-1:0];
            return neg ? (~v + 1'b1) : v;
        endfunction

        function logic signed [pbr_pkg::ACC_W-1:0] poly_at(logic signed [pbr_pkg::X_W-1:0] x);
            int                               d;
            logic signed [pbr_pkg::ACC_W-1:0] acc, xw;
            d = (int'(degree) > pbr_pkg::MAX_DEGREE) ? pbr_pkg::MAX_DEGREE : int'(degree);
            xw = {{(pbr_pkg::ACC_W-pbr_pkg::X_W){x[pbr_pkg::X_W-1]}}, x};
            acc = coef_term(coef[pbr_pkg::COEF_IDX_W'(d)]);
            for (int i = d; i > 0; i--) begin
                acc = sat_sum(scaled_product(acc, xw),
                              coef_term(coef[pbr_pkg::COEF_IDX_W'(i-1)]));
            end
            return acc;
        endfunction

        function int sign_of(logic signed [pbr_pkg::ACC_W-1:0] v);
            if (v > 0) return 1;
            if (v < 0) return -1;
            return 0;
        endfunction

        function bit near_zero(logic signed [pbr_pkg::ACC_W-1:0] v);
            return (v < pbr_pkg::TOL_LSB) && (v > -pbr_pkg::TOL_LSB);
        endfunction

        function logic signed [pbr_pkg::X_W-1:0] mid_of(logic signed [pbr_pkg::X_W-1:0] a, b);
            logic [pbr_pkg::X_W:0] s;
            s = {a[pbr_pkg::X_W-1], a} + {b[pbr_pkg::X_W-1], b};
            return s[pbr_pkg::X_W:1];
        endfunction

        function bit brackets(logic signed [pbr_pkg::X_W-1:0] lo, hi);
            return sign_of(poly_at(lo)) * sign_of(poly_at(hi)) <= 0;
        endfunction

        function void note_interval(logic signed [pbr_pkg::X_W-1:0] lo, hi);
            logic signed [pbr_pkg::X_W-1:0]   a, b, c;
            logic signed [pbr_pkg::ACC_W-1:0] fa, fb, fc;
            int                               n;
            root_result_t                     r;
            a = lo;
            b = hi;
            fa = poly_at(a);
            fb = poly_at(b);
            if (sign_of(fa) * sign_of(fb) > 0) begin
                r.root = '0;
                r.status = pbr_pkg::ST_SAME_SIGN;
                r.iterations = '0;
            end else begin
                c = mid_of(a, b);
                fc = poly_at(c);
                n = 0;
                while (!near_zero(fc) && n < pbr_pkg::MAX_ITER) begin
                    if (sign_of(fa) * sign_of(fc) < 0) begin
                        b = c;
                    end else begin
                        a = c;
                        fa = fc;
                    end
                    c = mid_of(a, b);
                    fc = poly_at(c);
                    n++;
                end
                r.root = c;
                r.status = near_zero(fc) ? pbr_pkg::ST_FOUND : pbr_pkg::ST_LIMIT;
                r.iterations = n[pbr_pkg::ITER_W-1:0];
            end
            expected_q.push_back(r);
        endfunction

        task check_result(input root_result_t got);
            root_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf(
                    "result beat with nothing pending: root=%h status=%0d iterations=%0d",
                    got.root, got.status, got.iterations));
                return;
            end
            want = expected_q.pop_front();
            if (got.root !== want.root || got.status !== want.status ||
                got.iterations !== want.iterations) begin
                report_mismatch($sformatf(
                    "root %h/%h status %0d/%0d iterations %0d/%0d (got/expected)",
                    got.root, want.root, got.status, want.status,
                    got.iterations, want.iterations));
            end
        endtask
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic [pbr_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pbr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pbr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    root_scoreboard sb = new();

    polynomial_bisection_root_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Result side: check each accepted beat, then pick the next ready level.
    // A toggle of hold_toggle starts a long hold-off counted here.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(root_result_t'(m_axis_tdata));
        end
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_interval(input logic signed [pbr_pkg::X_W-1:0] lo,
                                 input logic signed [pbr_pkg::X_W-1:0] hi);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata <= {hi, lo};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_interval(lo, hi);
    endtask

    // Stop offering and wait until every pending result has been taken.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [pbr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pbr_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_poly(input logic [pbr_pkg::CFG_DATA_W-1:0] deg,
                             input pbr_pkg::coef_t c [pbr_pkg::NUM_COEF]);
        wait_idle();
        write_cfg(pbr_pkg::REG_DEGREE, deg);
        for (int i = 0; i < pbr_pkg::NUM_COEF; i++) begin
            write_cfg(pbr_pkg::REG_COEF_BASE + pbr_pkg::CFG_INDEX_W'(i), c[i]);
        end
        // Unused indexes must leave the polynomial alone.
        write_cfg(pbr_pkg::CFG_INDEX_W'(REG_UNUSED_BASE + $urandom_range(0, 7)),
                  pbr_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_poly();
        pbr_pkg::coef_t                 c [pbr_pkg::NUM_COEF];
        logic [pbr_pkg::CFG_DATA_W-1:0] deg;
        int                             roll;
        roll = $urandom_range(99);
        deg = pbr_pkg::CFG_DATA_W'($urandom);
        deg[pbr_pkg::DEGREE_W-1:0] = pbr_pkg::DEGREE_W'(
            roll < 3 ? 0 : roll < 33 ? 1 : roll < 62 ? 2 : roll < 80 ? 3 :
            roll < 89 ? 4 : roll < 94 ? 5 : roll < 97 ? 6 : 7);
        for (int i = 0; i < pbr_pkg::NUM_COEF; i++) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                c[i] = pbr_pkg::COEF_W'($urandom_range(16) - 8);
            end else if (roll < 90) begin
                c[i] = pbr_pkg::COEF_W'($urandom);
            end else begin
                c[i] = roll[0] ? 16'sh7fff : 16'sh8000;
            end
        end
        load_poly(deg, c);
    endtask

    task automatic random_items(input int count);
        logic signed [pbr_pkg::X_W-1:0] lo, hi;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 75) begin
                // Mostly short intervals that straddle a sign change, so the
                // search actually runs; give up after a few tries.
                for (int t = 0; t < 24; t++) begin
                    lo = $signed($urandom) >>> $urandom_range(8, 15);
                    hi = $signed($urandom) >>> $urandom_range(8, 15);
                    if (sb.brackets(lo, hi)) break;
                end
            end else begin
                lo = $urandom;
                hi = $urandom;
            end
            send_interval(lo, hi);
        end
    endtask

    initial begin
        pbr_pkg::coef_t cset [pbr_pkg::NUM_COEF];

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero polynomial out of reset: the first midpoint is already a root.
        send_interval(0, 0);
        send_interval(X_MIN, X_MAX);
        send_interval(X_MAX, X_MIN);

        cset = '{-2, 0, 1, 0, 0, 0, 0};
        load_poly(2, cset);
        send_interval(0, 2 * Q_ONE);
        send_interval(2 * Q_ONE, 0);
        send_interval(0, Q_ONE);
        send_interval(-2 * Q_ONE, 2 * Q_ONE);

        // Exact root at 3.0, also hit directly at an interval end.
        cset = '{-3, 1, 0, 0, 0, 0, 0};
        load_poly(1, cset);
        send_interval(0, 8 * Q_ONE);
        send_interval(3 * Q_ONE, 5 * Q_ONE);
        send_interval(5 * Q_ONE, 3 * Q_ONE);
        send_interval(-8 * Q_ONE, 0);

        cset = '{5, 0, 0, 0, 0, 0, 0};
        load_poly(0, cset);
        send_interval(-Q_ONE, Q_ONE);

        cset = '{-1, 0, 0, 0, 0, 0, 1};
        load_poly(6, cset);
        send_interval(0, 4 * Q_ONE);
        send_interval(-4 * Q_ONE, 0);

        // Degree field of seven folds back to six; extreme coefficients saturate.
        cset = '{32767, -32768, 32767, -32768, 32767, -32768, 32767};
        load_poly(16'hffff, cset);
        send_interval(X_MIN, X_MAX);
        send_interval(X_MAX, X_MAX);
        send_interval(X_MIN, 0);
        send_interval(0, X_MAX);

        cset = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768};
        load_poly(16'h7ff6, cset);
        send_interval(X_MIN, X_MAX);
        send_interval(X_MAX, X_MIN);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct <= 0;
                end
                1: begin
                    src_idle_pct = 68;
                    sink_stall_pct <= 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct <= 68;
                end
                default: begin
                    src_idle_pct = 12;
                    sink_stall_pct <= 12;
                end
            endcase
            for (int k = 0; k < CONFIGS_PER_PHASE; k++) begin
                load_random_poly();
                if (phase == 0 && k == 1) begin
                    hold_toggle <= ~hold_toggle;
                end
                random_items(ITEMS_PER_CONFIG);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[polynomial_bisection_root_core] OK");
        end else begin
            $display("[polynomial_bisection_root_core] ERROR");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("[polynomial_bisection_root_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/pbr_pkg.sv
rtl/pbr_datapath.sv
rtl/pbr_ctrl.sv
rtl/polynomial_bisection_root_core.sv
rtl/pbr_checker.sv
test/tb_top.sv
